FILE: rtl/utf8d_pkg.sv
// shared types and constants of the utf-8 stream decoder
package utf8d_pkg;

	// longest sequence accepted, 1 to 4; longer leads are dropped
	localparam int MAX_SEQUENCE_LENGTH = 4;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int LEN_W  = 3;
	localparam int REM_W  = 2;
	localparam int PAY_W  = 7;

	// byte queue between classifier and decode engine, power of two
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEQUENCE_LENGTH);

	typedef enum logic [1:0] {
		KIND_ASCII,
		KIND_CONT,
		KIND_LEAD,
		KIND_DROP
	} byte_kind_t;

	// one classified byte
	typedef struct packed {
		byte_kind_t         kind;
		logic [LEN_W-1:0]   len;
		logic [PAY_W-1:0]   payload;
	} item_t;

endpackage

FILE: rtl/utf8d_front.sv
// byte classifier: leading-one decode and payload extraction into the queue
module utf8d_front (
	input  logic                          byte_valid,
	output logic                          byte_stall,
	input  logic [utf8d_pkg::BYTE_W-1:0]  stream_byte,
	input  logic                          queue_full,
	output logic                          push,
	output utf8d_pkg::item_t              item
);
	import utf8d_pkg::*;

	logic [LEN_W-1:0] lead_len;

	assign byte_stall = queue_full;
	assign push       = byte_valid && !queue_full;

	always_comb begin
		lead_len     = '0;
		item.kind    = KIND_DROP;
		item.len     = '0;
		item.payload = '0;
		unique casez (stream_byte)
			8'b0???????: begin
				item.kind    = KIND_ASCII;
				item.len     = LEN_W'(1);
				item.payload = stream_byte[PAY_W-1:0];
			end
			8'b10??????: begin
				item.kind    = KIND_CONT;
				item.payload = {1'b0, stream_byte[5:0]};
			end
			8'b110?????: begin
				lead_len     = LEN_W'(2);
				item.payload = {2'b00, stream_byte[4:0]};
			end
			8'b1110????: begin
				lead_len     = LEN_W'(3);
				item.payload = {3'b000, stream_byte[3:0]};
			end
			8'b11110???: begin
				lead_len     = LEN_W'(4);
				item.payload = {4'b0000, stream_byte[2:0]};
			end
			default: begin
				item.kind = KIND_DROP;
			end
		endcase
		if (lead_len != '0) begin
			if (lead_len > MAX_LEN) begin
				item.kind = KIND_DROP;
			end else begin
				item.kind = KIND_LEAD;
				item.len  = lead_len;
			end
		end
	end

endmodule

FILE: rtl/utf8d_queue.sv
// small fifo of classified bytes between front and back
module utf8d_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utf8d_pkg::item_t  push_item,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output utf8d_pkg::item_t  head
);
	import utf8d_pkg::*;

	item_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/utf8d_back.sv
// decode engine: sequence state, payload accumulation and output register
module utf8d_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         queue_empty,
	input  utf8d_pkg::item_t             head,
	output logic                         pop,
	output logic                         cp_valid,
	input  logic                         cp_stall,
	output logic [utf8d_pkg::CP_W-1:0]   scalar_value,
	output logic [utf8d_pkg::LEN_W-1:0]  sequence_length
);
	import utf8d_pkg::*;

	logic [REM_W-1:0]  rem_q;
	logic [LEN_W-1:0]  open_len_q;
	logic [CP_W-1:0]   acc_q;
	logic              cp_valid_q;
	logic [CP_W-1:0]   scalar_value_q;
	logic [LEN_W-1:0]  sequence_length_q;

	logic [CP_W-1:0]   acc_next;
	logic [LEN_W-1:0]  len_m1;

	assign cp_valid        = cp_valid_q;
	assign scalar_value    = scalar_value_q;
	assign sequence_length = sequence_length_q;

	// take the next byte whenever the output register is free or drains now
	assign pop      = !queue_empty && (!cp_valid_q || !cp_stall);
	assign acc_next = {acc_q[CP_W-7:0], head.payload[5:0]};
	assign len_m1   = head.len - LEN_W'(1);

	always_ff @(posedge clk) begin
		if (pop) begin
			if (head.kind == KIND_ASCII) begin
				scalar_value_q    <= CP_W'(head.payload);
				sequence_length_q <= head.len;
			end else begin
				scalar_value_q    <= acc_next;
				sequence_length_q <= open_len_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			open_len_q <= '0;
			acc_q      <= '0;
			cp_valid_q <= 1'b0;
		end else begin
			if (cp_valid_q && !cp_stall) begin
				cp_valid_q <= 1'b0;
			end
			if (pop) begin
				case (head.kind)
					KIND_CONT: begin
						if (rem_q != '0) begin
							rem_q <= rem_q - REM_W'(1);
							if (rem_q == REM_W'(1)) begin
								cp_valid_q <= 1'b1;
								open_len_q <= '0;
								acc_q      <= '0;
							end else begin
								acc_q <= acc_next;
							end
						end
					end
					KIND_ASCII: begin
						rem_q      <= '0;
						open_len_q <= '0;
						acc_q      <= '0;
						cp_valid_q <= 1'b1;
					end
					KIND_LEAD: begin
						rem_q      <= len_m1[REM_W-1:0];
						open_len_q <= head.len;
						acc_q      <= CP_W'(head.payload);
					end
					default: begin
						rem_q      <= '0;
						open_len_q <= '0;
						acc_q      <= '0;
					end
				endcase
			end
		end
	end

endmodule

FILE: rtl/utf8_stream_decoder.sv
// top level of the utf-8 stream decoder: classifier, byte queue, decode engine
//
//   channel   signals                         beat
//   -------   -----------------------------   ------------------------------------
//   bytes     byte_valid, byte_stall          stream_byte, one raw byte
//   points    cp_valid, cp_stall              scalar_value, sequence_length
//
// one byte per clock sustained while cp_stall stays low; an accepted byte is
// registered in a two-entry queue, and the decode engine pops it from the queue
// head and loads the output register at that same edge, so a completed code
// point shows once its last byte has passed the queue and the output register
// byte_stall rises only when the queue is full: two beats waiting behind a
// held code point
// arst_n clears the queue, the open sequence and the output valid
module utf8_stream_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	output logic                         byte_stall,
	input  logic [utf8d_pkg::BYTE_W-1:0] stream_byte,
	output logic                         cp_valid,
	input  logic                         cp_stall,
	output logic [utf8d_pkg::CP_W-1:0]   scalar_value,
	output logic [utf8d_pkg::LEN_W-1:0]  sequence_length
);
	import utf8d_pkg::*;

	// classified byte on its way into the queue
	item_t  front_item;
	logic   front_push;

	// queue head as seen by the decode engine
	item_t  head_item;
	logic   queue_full;
	logic   queue_empty;
	logic   back_pop;

	// front: leading-one decode, overlong leads marked for dropping
	utf8d_front u_front (
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.stream_byte (stream_byte),
		.queue_full  (queue_full),
		.push        (front_push),
		.item        (front_item)
	);

	// decouples byte intake from output back-pressure
	utf8d_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (back_pop),
		.empty     (queue_empty),
		.head      (head_item)
	);

	// back: open-sequence state, accumulation and the result register
	utf8d_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.queue_empty     (queue_empty),
		.head            (head_item),
		.pop             (back_pop),
		.cp_valid        (cp_valid),
		.cp_stall        (cp_stall),
		.scalar_value    (scalar_value),
		.sequence_length (sequence_length)
	);

endmodule

FILE: bench/tb.sv
// self-checking bench for the utf-8 stream decoder: directed and random byte streams
`timescale 1ns / 100ps

module tb;

	import utf8d_pkg::*;

	// cycles with no beat on either channel before the run is called hung
	localparam int WATCHDOG_LIMIT = 2000;
	// quiet cycles after the last expected code point
	localparam int TAIL_CYCLES    = 8;
	// random bytes per pacing phase, three phases in all
	localparam int PHASE_BYTES    = 174;

	// byte classes as the predictor sees them
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [7:0] FIRST_BAD = 8'hF8;

	typedef struct packed {
		logic [CP_W-1:0]  cp;
		logic [LEN_W-1:0] len;
	} point_t;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                byte_valid      = 1'b0;
	logic [BYTE_W-1:0]   stream_byte     = '0;
	logic                cp_stall        = 1'b0;
	logic                byte_stall;
	logic                cp_valid;
	logic [CP_W-1:0]     scalar_value;
	logic [LEN_W-1:0]    sequence_length;

	// decoder state as predicted
	logic [REM_W-1:0]    cont_left;
	logic [LEN_W-1:0]    seq_len;
	logic [CP_W-1:0]     seq_bits;

	// code points still owed by the decoder, oldest first
	point_t              owed_points[$];

	int                  gap_pct    = 0;
	int                  stall_pct  = 0;
	int                  fail_count = 0;
	int                  bytes_in   = 0;
	int                  points_out = 0;
	int                  len_seen[1:4];
	int                  quiet_cycles = 0;

	utf8_stream_decoder uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.byte_valid      (byte_valid),
		.byte_stall      (byte_stall),
		.stream_byte     (stream_byte),
		.cp_valid        (cp_valid),
		.cp_stall        (cp_stall),
		.scalar_value    (scalar_value),
		.sequence_length (sequence_length)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor: one accepted byte in, zero or one code point owed
	// ------------------------------------------------------------------
	task automatic decode_byte(input logic [BYTE_W-1:0] b);
		int ones;
		if (cont_left != 0) begin
			if (b[7:6] == CONT_TAG) begin
				// six more payload bits; the top of the accumulator falls off
				seq_bits  = {seq_bits[CP_W-7:0], b[5:0]};
				cont_left = cont_left - REM_W'(1);
				if (cont_left == 0) begin
					owed_points.push_back('{cp: seq_bits, len: seq_len});
					seq_len  = '0;
					seq_bits = '0;
				end
				return;
			end
			// anything else breaks the open sequence and is then decoded afresh
			cont_left = '0;
			seq_len   = '0;
			seq_bits  = '0;
		end
		casez (b)
			8'b0???????: ones = 0;
			8'b10??????: ones = 1;
			8'b110?????: ones = 2;
			8'b1110????: ones = 3;
			8'b11110???: ones = 4;
			default:     ones = 5;
		endcase
		if (ones == 0) begin
			owed_points.push_back('{cp: CP_W'(b), len: LEN_W'(1)});
			return;
		end
		// stray continuation or a lead too long for the decoder: dropped
		if (ones == 1 || ones > MAX_SEQUENCE_LENGTH || ones > 4)
			return;
		case (ones)
			2:       seq_bits = CP_W'(b[4:0]);
			3:       seq_bits = CP_W'(b[3:0]);
			default: seq_bits = CP_W'(b[2:0]);
		endcase
		cont_left = REM_W'(ones - 1);
		seq_len   = LEN_W'(ones);
	endtask

	// ------------------------------------------------------------------
	// byte channel driver; valid stays high from beat to beat unless a gap
	// is drawn, so it is never lowered and raised in the same step
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < gap_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid  <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (byte_stall);
		bytes_in++;
		decode_byte(b);
	endtask

	// encode a value as a sequence of len bytes, send only the first nbytes
	task automatic send_encoded(input logic [CP_W-1:0] cp, input int len, input int nbytes);
		logic [BYTE_W-1:0] seq [4];
		int i;
		seq[1] = {CONT_TAG, cp[5:0]};
		seq[2] = {CONT_TAG, cp[5:0]};
		seq[3] = {CONT_TAG, cp[5:0]};
		case (len)
			1: seq[0] = {1'b0, cp[6:0]};
			2: seq[0] = {3'b110, cp[10:6]};
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {CONT_TAG, cp[11:6]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {CONT_TAG, cp[17:12]};
				seq[2] = {CONT_TAG, cp[11:6]};
			end
		endcase
		for (i = 0; i < nbytes; i++)
			send_byte(seq[i]);
	endtask

	// hold the byte channel until every owed code point is out
	task automatic drain_points();
		byte_valid <= 1'b0;
		do @(posedge clk); while (owed_points.size() != 0);
	endtask

	// ------------------------------------------------------------------
	// output side: random stall and in-order comparison
	// ------------------------------------------------------------------
	always @(posedge clk) begin : point_check
		point_t want;
		cp_stall <= ($urandom_range(99) < stall_pct);
		// cp_stall here is still the value that held up to this edge
		if (arst_n && cp_valid && !cp_stall) begin
			if (owed_points.size() == 0) begin
				$display("%0t: code point with none owed: expected nothing, actual %h len %0d",
					$time, scalar_value, sequence_length);
				fail_count++;
			end else begin
				want = owed_points.pop_front();
				if (scalar_value !== want.cp) begin
					$display("%0t: scalar_value mismatch: expected %h, actual %h",
						$time, want.cp, scalar_value);
					fail_count++;
				end
				if (sequence_length !== want.len) begin
					$display("%0t: sequence_length mismatch: expected %0d, actual %0d",
						$time, want.len, sequence_length);
					fail_count++;
				end
				points_out++;
				if (want.len >= 1 && want.len <= 4)
					len_seen[want.len]++;
			end
		end
	end

	// watchdog: a run that stops moving beats is a failure
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (cp_valid && !cp_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d code points still owed",
				$time, quiet_cycles, owed_points.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------
	task automatic test_ascii_extremes();
		send_byte(8'h00);
		send_byte(8'h7F);
	endtask

	task automatic test_two_byte();
		// largest two-byte value
		send_byte(8'hDF);
		send_byte(8'hBF);
	endtask

	task automatic test_three_byte();
		send_byte(8'hEF);
		send_byte(8'hBF);
		send_byte(8'hBF);
		// surrogate, passed through unchecked
		send_byte(8'hED);
		send_byte(8'hA0);
		send_byte(8'h80);
	endtask

	task automatic test_four_byte();
		// all payload bits set, beyond the unicode range
		send_byte(8'hF7);
		send_byte(8'hBF);
		send_byte(8'hBF);
		send_byte(8'hBF);
	endtask

	task automatic test_stray_continuation();
		send_byte(8'h80);
		send_byte(8'hBF);
	endtask

	task automatic test_overlong_lead();
		send_byte(FIRST_BAD);
		send_byte(8'hFF);
	endtask

	task automatic test_interrupted_sequence();
		// three-byte sequence broken by ascii
		send_byte(8'hE2);
		send_byte(8'h82);
		send_byte(8'h41);
		// two-byte lead broken by a four-byte lead that then completes
		send_byte(8'hC3);
		send_encoded(CP_W'(21'h10000), 4, 4);
	endtask

	// mostly well-formed sequences with random payload, the rest noise
	task automatic test_random_stream(input int target);
		int sent;
		int pick;
		int len;
		int cut;
		logic [CP_W-1:0] cp;
		sent = 0;
		while (sent < target) begin
			pick = $urandom_range(99);
			len  = $urandom_range(1, 4);
			cp   = CP_W'($urandom);
			case (len)
				1: cp = cp & 21'h7F;
				2: cp = cp & 21'h7FF;
				3: cp = cp & 21'hFFFF;
				default: ;
			endcase
			if (pick < 80) begin
				send_encoded(cp, len, len);
				sent += len;
			end else if (pick < 88) begin
				// cut short; any following byte that is not a continuation discards it
				len = $urandom_range(2, 4);
				cut = $urandom_range(1, len - 1);
				send_encoded(cp, len, cut);
				sent += cut;
			end else if (pick < 94) begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
				sent++;
			end else if (pick < 97) begin
				send_byte({CONT_TAG, 6'($urandom)});
				sent++;
			end else begin
				send_byte(BYTE_W'($urandom_range(FIRST_BAD, 8'hFF)));
				sent++;
			end
		end
	endtask

	// a partial sequence at the very end must never come out
	task automatic test_truncated_end();
		send_byte(8'hF0);
		send_byte(8'h9F);
	endtask

	// ------------------------------------------------------------------
	// sequence of the run
	// ------------------------------------------------------------------
	initial begin
		cont_left = '0;
		seq_len   = '0;
		seq_bits  = '0;
		for (int k = 1; k <= 4; k++)
			len_seen[k] = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender mostly busy, receiver mostly stalled
		gap_pct   = 6;
		stall_pct = 73;
		test_ascii_extremes();
		test_two_byte();
		test_three_byte();
		test_four_byte();
		test_stray_continuation();
		test_overlong_lead();
		test_interrupted_sequence();
		drain_points();
		test_random_stream(PHASE_BYTES);
		drain_points();

		// sender mostly idle, receiver mostly ready
		gap_pct   = 73;
		stall_pct = 6;
		test_random_stream(PHASE_BYTES);
		drain_points();

		// full rate both ways
		gap_pct   = 0;
		stall_pct = 0;
		test_random_stream(PHASE_BYTES);
		test_truncated_end();
		byte_valid <= 1'b0;

		while (owed_points.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d bytes in three pacing phases, %0d code points checked",
			bytes_in, points_out);
		$display("lengths 1..4 seen %0d/%0d/%0d/%0d, with stray, overlong, broken and cut sequences",
			len_seen[1], len_seen[2], len_seen[3], len_seen[4]);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
